// ===== src/cbfc_pkg.sv =====
// shared types and constants of the cnf brute-force checker
package cbfc_pkg;

   // variable count the port widths are built for
   localparam int MAX_VARS = 16;
   localparam int VAR_W    = 4;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_WRITE = 2'd0;
   localparam kind_type KIND_CHECK = 2'd1;
   localparam kind_type KIND_SOLVE = 2'd2;
   localparam kind_type KIND_NONE  = 2'd3;

   typedef logic [0:0] reg_index_type;
   localparam reg_index_type REG_CLAUSES_IN_USE = 1'b0;
   localparam reg_index_type REG_VARS_IN_USE    = 1'b1;

   localparam int CSR_DATA_W = 7;

   typedef struct packed {
      logic [VAR_W-1:0] variable;
      logic             polarity;
      logic             used;
   } lit_type;

   typedef struct packed {
      kind_type              kind;
      logic [5:0]            clause_index;
      logic [1:0]            literal_slot;
      logic [VAR_W-1:0]      literal_variable;
      logic                  literal_polarity;
      logic                  literal_used;
      logic [MAX_VARS-1:0]   assignment;
      logic [MAX_VARS-1:0]   fixed_mask;
   } req_type;

   typedef struct packed {
      logic                  satisfied;
      logic [MAX_VARS:0]     solution_count;
      logic [MAX_VARS-1:0]   frozen_mask;
      logic [MAX_VARS-1:0]   frozen_values;
   } rsp_type;

endpackage

// ===== src/cbfc_clause_eval.sv =====
// evaluates one clause row against one assignment
module cbfc_clause_eval #(
   parameter int LITS_PER_CLAUSE = 3
) (
   input  cbfc_pkg::lit_type [LITS_PER_CLAUSE-1:0] row_i,
   input  logic [cbfc_pkg::MAX_VARS-1:0]           assignment_i,
   output logic                                    clause_true_o
);

   always_comb begin
      logic hit;
      hit = 1'b0;
      for (int s = 0; s < LITS_PER_CLAUSE; s++) begin
         // a used slot whose variable takes the polarity value
         if (row_i[s].used && (assignment_i[row_i[s].variable] == row_i[s].polarity)) begin
            hit = 1'b1;
         end
      end
      clause_true_o = hit;
   end

endmodule

// ===== src/cnf_brute_force_checker.sv =====
// top level of the cnf brute-force checker: clause memory, sequencer, result register
//
//   channel  direction  handshake              beat
//   req      in         req_valid / req_stall  cbfc_pkg::req_type (write, check or solve)
//   rsp      out        rsp_valid / rsp_stall  cbfc_pkg::rsp_type (one per req beat)
//   csr      in         csr_write_enable       csr_index, csr_write_data
//
// a write or unknown kind answers in the cycle after it is taken. a check tests the one
// given assignment, a solve every assignment of its free variables: one clause row is
// read from the clause memory and tested by the shared clause evaluator per cycle, and
// an assignment stops at its first false clause.
// synchronous reset clears the sequencer, result valid and clauses in use, sets vars
// in use to MAX_VARS; the clause memory is not cleared, unwritten rows are undefined.
// req is stalled while a check or solve runs and while an untaken result waits.
module cnf_brute_force_checker #(
   parameter int MAX_CLAUSES     = 64,
   parameter int LITS_PER_CLAUSE = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  cbfc_pkg::req_type                 req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output cbfc_pkg::rsp_type                 rsp_payload,
   input  logic                              csr_write_enable,
   input  cbfc_pkg::reg_index_type           csr_index,
   input  logic [cbfc_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   localparam int NV     = cbfc_pkg::MAX_VARS;
   localparam int ROW_W  = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;
   localparam int CNT_W  = $clog2(MAX_CLAUSES + 1);
   localparam int SLOT_W = (LITS_PER_CLAUSE > 1) ? $clog2(LITS_PER_CLAUSE) : 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EVAL = 2'b10
   } state_type;

   // csr registers
   logic [6:0]      clauses_in_use_ff;
   logic [4:0]      vars_in_use_ff;

   // sequencer and job registers
   state_type       state_ff, state_in;
   logic [ROW_W-1:0] clause_ff, clause_in;
   logic [CNT_W-1:0] m_ff;
   logic            solve_ff;
   logic [NV-1:0]   nmask_ff, base_ff, free_ff, sub_ff, sub_in;
   logic [NV-1:0]   all_one_ff, all_one_in, all_zero_ff, all_zero_in;
   logic [NV:0]     count_ff, count_in;

   // clause memory
   cbfc_pkg::lit_type [LITS_PER_CLAUSE-1:0] mem_ff [MAX_CLAUSES];
   cbfc_pkg::lit_type [LITS_PER_CLAUSE-1:0] rd_data_ff;
   logic [ROW_W-1:0] rd_addr;

   // result register
   logic            rsp_valid_ff;
   cbfc_pkg::rsp_type rsp_payload_ff, rsp_result;
   logic            rsp_load;

   logic            req_accept;
   logic [4:0]      n_act;
   logic [NV-1:0]   nmask;
   logic [31:0]     m_wide, row_wide, slot_wide;
   logic            wr_ok;
   logic [NV-1:0]   assign_now, fixed_now;
   logic            clause_true, last_clause, assign_done, assign_ok, finish;
   logic [CNT_W-1:0] clause_next;

   // active variable count and mask, saturated to the port width
   assign n_act  = (vars_in_use_ff > 5'(NV)) ? 5'(NV) : vars_in_use_ff;
   assign nmask  = (n_act >= 5'(NV)) ? '1 : NV'(((NV+1)'(1) << n_act) - (NV+1)'(1));
   assign m_wide = (32'(clauses_in_use_ff) > 32'(MAX_CLAUSES)) ? 32'(MAX_CLAUSES)
                                                               : 32'(clauses_in_use_ff);

   assign row_wide  = 32'(req_payload.clause_index);
   assign slot_wide = 32'(req_payload.literal_slot);
   assign wr_ok     = (row_wide < 32'(MAX_CLAUSES)) && (slot_wide < 32'(LITS_PER_CLAUSE));

   // an item is taken only when idle and the result slot is free or emptying
   assign req_stall  = !((state_ff == ST_IDLE) && (!rsp_valid_ff || !rsp_stall));
   assign req_accept = req_valid && !req_stall;

   // the shared clause evaluator
   assign assign_now = base_ff | sub_ff;

   cbfc_clause_eval #(
      .LITS_PER_CLAUSE (LITS_PER_CLAUSE)
   ) u_eval (
      .row_i         (rd_data_ff),
      .assignment_i  (assign_now),
      .clause_true_o (clause_true)
   );

   assign clause_next = CNT_W'(clause_ff) + CNT_W'(1);
   assign last_clause = (clause_next == m_ff);
   // no clauses in use: every assignment holds
   assign assign_done = (m_ff == '0) || !clause_true || last_clause;
   assign assign_ok   = (m_ff == '0) || (clause_true && last_clause);
   assign finish      = (state_ff == ST_EVAL) && assign_done &&
                        (((sub_ff - free_ff) & free_ff) == '0);

   assign fixed_now = (req_payload.kind == cbfc_pkg::KIND_SOLVE)
                      ? (req_payload.fixed_mask & nmask) : nmask;

   always_comb begin
      state_in    = state_ff;
      clause_in   = clause_ff;
      sub_in      = sub_ff;
      count_in    = count_ff;
      all_one_in  = all_one_ff;
      all_zero_in = all_zero_ff;
      rd_addr     = '0;
      if (state_ff == ST_EVAL) begin
         if (assign_done) begin
            // assignment finished: fold it in and step to the next free subset
            if (assign_ok) begin
               count_in    = count_ff + (NV+1)'(1);
               all_one_in  = all_one_ff & assign_now;
               all_zero_in = all_zero_ff & ~assign_now;
            end
            sub_in    = (sub_ff - free_ff) & free_ff;
            clause_in = '0;
            if (finish) begin
               state_in = ST_IDLE;
            end
         end else begin
            clause_in = clause_next[ROW_W-1:0];
            rd_addr   = clause_next[ROW_W-1:0];
         end
      end else if (req_accept && ((req_payload.kind == cbfc_pkg::KIND_CHECK) ||
                                  (req_payload.kind == cbfc_pkg::KIND_SOLVE))) begin
         state_in = ST_EVAL;
      end
   end

   // result of the current beat
   always_comb begin
      rsp_result = '0;
      rsp_load   = 1'b0;
      if (finish) begin
         rsp_load = 1'b1;
         if (!solve_ff) begin
            rsp_result.satisfied = (count_in != '0);
         end else if (count_in == '0) begin
            // no solution: every active variable counts as frozen
            rsp_result.frozen_mask = nmask_ff;
         end else begin
            rsp_result.satisfied      = 1'b1;
            rsp_result.solution_count = count_in;
            rsp_result.frozen_mask    = (all_one_in | all_zero_in) & nmask_ff;
            rsp_result.frozen_values  = all_one_in & nmask_ff;
         end
      end else if (req_accept && ((req_payload.kind == cbfc_pkg::KIND_WRITE) ||
                                  (req_payload.kind == cbfc_pkg::KIND_NONE))) begin
         rsp_load = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         rsp_valid_ff      <= 1'b0;
         clauses_in_use_ff <= 7'd0;
         vars_in_use_ff    <= 5'(NV);
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            unique case (csr_index)
               cbfc_pkg::REG_CLAUSES_IN_USE: clauses_in_use_ff <= csr_write_data[6:0];
               cbfc_pkg::REG_VARS_IN_USE:    vars_in_use_ff    <= csr_write_data[4:0];
               default: ;
            endcase
         end
      end
   end

   // job registers
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_payload_ff <= rsp_result;
      end
      if (state_ff == ST_IDLE) begin
         clause_ff   <= '0;
         m_ff        <= m_wide[CNT_W-1:0];
         solve_ff    <= (req_payload.kind == cbfc_pkg::KIND_SOLVE);
         nmask_ff    <= nmask;
         base_ff     <= req_payload.assignment & fixed_now;
         free_ff     <= nmask & ~fixed_now;
         sub_ff      <= '0;
         count_ff    <= '0;
         all_one_ff  <= nmask;
         all_zero_ff <= nmask;
      end else begin
         clause_ff   <= clause_in;
         sub_ff      <= sub_in;
         count_ff    <= count_in;
         all_one_ff  <= all_one_in;
         all_zero_ff <= all_zero_in;
      end
   end

   // clause memory: one slot written, one row read per cycle
   always_ff @(posedge clock) begin
      if (req_accept && (req_payload.kind == cbfc_pkg::KIND_WRITE) && wr_ok) begin
         mem_ff[row_wide[ROW_W-1:0]][slot_wide[SLOT_W-1:0]] <= '{
            variable: req_payload.literal_variable,
            polarity: req_payload.literal_polarity,
            used:     req_payload.literal_used
         };
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // the result slot is always empty when a check or solve ends
   a_finish_slot_free: assert property (@(posedge clock) disable iff (reset)
      finish |-> !rsp_valid_ff)
      else $error("check or solve finished while a result was pending");

   // input is held off during a run
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) |-> req_stall)
      else $error("input taken during a run");

   // a taken check or solve starts a run
   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && ((req_payload.kind == cbfc_pkg::KIND_CHECK) ||
                      (req_payload.kind == cbfc_pkg::KIND_SOLVE))) |=> (state_ff == ST_EVAL))
      else $error("run did not start");

   // a nonzero count always comes with satisfied
   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_payload_ff.solution_count != '0)) |-> rsp_payload_ff.satisfied)
      else $error("solutions counted without satisfied");

endmodule

// ===== tb/cnf_brute_force_checker_test.sv =====
// self-checking testbench of the cnf brute-force checker: clause writes, checks and solves
module cnf_brute_force_checker_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_ROWS      = 64;
   localparam int ROW_SLOTS       = 3;
   // rows 0..3 hold the known formula, rows from there below FILLED_ROWS are filled at random
   localparam int KNOWN_ROWS      = 4;
   localparam int FILLED_ROWS     = 8;
   localparam int RANDOM_PHASES   = 3;
   localparam int ITEMS_PER_PHASE = 20;
   localparam int LONG_HOLD       = 300;
   localparam int DRAIN_CYCLES    = 10;
   // far above the slowest legal run, mostly bounded by the wide solves
   localparam int unsigned CYCLE_LIMIT = 6_000_000;

   // expected answers of the block, worked out from its own copy of clause memory and csrs
   class cnf_scoreboard;
      cbfc_pkg::lit_type  clause_rows [STORE_ROWS][ROW_SLOTS];
      logic [6:0]         clauses_reg;
      logic [4:0]         vars_reg;
      cbfc_pkg::rsp_type  awaited_answers [$];
      int                 mismatches;

      function new();
         clauses_reg = 7'd0;
         vars_reg    = 5'd16;
         mismatches  = 0;
      endfunction

      function void write_register(cbfc_pkg::reg_index_type idx, logic [6:0] data);
         if (idx == cbfc_pkg::REG_CLAUSES_IN_USE)
            clauses_reg = data;
         else if (idx == cbfc_pkg::REG_VARS_IN_USE)
            vars_reg = data[4:0];
      endfunction

      // true when each of the first rows clauses has a used slot matching its variable
      function bit formula_holds(logic [15:0] values, int rows);
         bit clause_true;
         for (int c = 0; c < rows; c++) begin
            clause_true = 1'b0;
            for (int s = 0; s < ROW_SLOTS; s++)
               if (clause_rows[c][s].used &&
                   values[clause_rows[c][s].variable] == clause_rows[c][s].polarity)
                  clause_true = 1'b1;
            if (!clause_true)
               return 1'b0;
         end
         return 1'b1;
      endfunction

      function void take_query(cbfc_pkg::req_type beat);
         cbfc_pkg::rsp_type answer;
         int          n;
         int          m;
         logic [15:0] live;
         logic [15:0] fixed;
         logic [15:0] base;
         logic [15:0] free_bits;
         logic [15:0] walk;
         logic [15:0] values;
         logic [15:0] all_one;
         logic [15:0] all_zero;
         answer = '0;
         n = (vars_reg > 16) ? 16 : vars_reg;
         m = (clauses_reg > STORE_ROWS) ? STORE_ROWS : clauses_reg;
         live = 16'((17'd1 << n) - 17'd1);
         case (beat.kind)
            cbfc_pkg::KIND_WRITE: begin
               // slot past the row width is dropped
               if (beat.literal_slot < ROW_SLOTS) begin
                  clause_rows[beat.clause_index][beat.literal_slot].variable =
                     beat.literal_variable;
                  clause_rows[beat.clause_index][beat.literal_slot].polarity =
                     beat.literal_polarity;
                  clause_rows[beat.clause_index][beat.literal_slot].used = beat.literal_used;
               end
            end
            cbfc_pkg::KIND_CHECK: begin
               answer.satisfied = formula_holds(beat.assignment & live, m);
            end
            cbfc_pkg::KIND_SOLVE: begin
               fixed     = beat.fixed_mask & live;
               base      = beat.assignment & fixed;
               free_bits = live & ~fixed;
               walk      = '0;
               all_one   = live;
               all_zero  = live;
               // walk every subset of the free bits, starting and ending at none
               do begin
                  values = base | walk;
                  if (formula_holds(values, m)) begin
                     answer.solution_count += 1;
                     all_one  &= values;
                     all_zero &= ~values;
                  end
                  walk = (walk - free_bits) & free_bits;
               end while (walk != 0);
               if (answer.solution_count == 0) begin
                  answer.frozen_mask = live;
               end else begin
                  answer.satisfied     = 1'b1;
                  answer.frozen_mask   = (all_one | all_zero) & live;
                  answer.frozen_values = all_one & live;
               end
            end
            default: ;
         endcase
         awaited_answers = {awaited_answers, answer};
      endfunction

      function void compare_field(string field, logic [16:0] want, logic [16:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void match_answer(cbfc_pkg::rsp_type got);
         cbfc_pkg::rsp_type want;
         if (awaited_answers.size() == 0) begin
            $display("%0t: result beat %h with nothing outstanding", $time, got);
            mismatches++;
            return;
         end
         want = awaited_answers.pop_front();
         compare_field("satisfied", 17'(want.satisfied), 17'(got.satisfied));
         compare_field("solution_count", want.solution_count, got.solution_count);
         compare_field("frozen_mask", 17'(want.frozen_mask), 17'(got.frozen_mask));
         compare_field("frozen_values", 17'(want.frozen_values), 17'(got.frozen_values));
      endfunction
   endclass

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // block inputs, known from time zero
   logic                            req_valid        = 1'b0;
   cbfc_pkg::req_type               req_payload      = '0;
   logic                            rsp_stall        = 1'b0;
   logic                            csr_write_enable = 1'b0;
   cbfc_pkg::reg_index_type         csr_index        = cbfc_pkg::REG_CLAUSES_IN_USE;
   logic [cbfc_pkg::CSR_DATA_W-1:0] csr_write_data   = '0;

   // block outputs
   logic              req_stall;
   logic              rsp_valid;
   cbfc_pkg::rsp_type rsp_payload;

   // test controls
   int          idle_percent      = 20;
   logic        long_hold_request = 1'b0;
   logic        long_hold_taken   = 1'b0;
   int          hold_cycles       = 0;
   int unsigned cycle_count       = 0;

   cnf_scoreboard formula_sb = new();

   cnf_brute_force_checker #(
      .MAX_CLAUSES     (STORE_ROWS),
      .LITS_PER_CLAUSE (ROW_SLOTS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d answers outstanding", $time,
                  formula_sb.awaited_answers.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side back-pressure: random short bursts, plus one long hold on request
   // so the block backs up and stalls the request channel
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         hold_cycles <= 0;
      end else if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
      end else if (long_hold_request && !long_hold_taken) begin
         rsp_stall       <= 1'b1;
         hold_cycles     <= LONG_HOLD - 1;
         long_hold_taken <= 1'b1;
      end else if ($urandom_range(99) < idle_percent) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= $urandom_range(13);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // result monitor: every taken beat is matched against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         formula_sb.match_answer(rsp_payload);
   end

   // random filler in the fields the kind does not use
   function automatic cbfc_pkg::req_type noisy_beat(cbfc_pkg::kind_type kind);
      logic [63:0]       noise;
      cbfc_pkg::req_type beat;
      noise = {$urandom, $urandom};
      beat = noise[$bits(cbfc_pkg::req_type)-1:0];
      beat.kind = kind;
      return beat;
   endfunction

   // offer one beat, maybe after an idle burst; returns in the step the beat is taken
   // with valid still high, so the next beat can follow back to back
   task automatic put_beat(input cbfc_pkg::req_type beat);
      if ($urandom_range(99) < idle_percent) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(14, 1)) @(posedge clock);
      end
      req_payload <= beat;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
      formula_sb.take_query(beat);
   endtask

   task automatic send_literal(input int row, input int slot, input int variable_index,
                               input bit polarity, input bit used);
      cbfc_pkg::req_type beat;
      beat = noisy_beat(cbfc_pkg::KIND_WRITE);
      beat.clause_index     = 6'(row);
      beat.literal_slot     = 2'(slot);
      beat.literal_variable = 4'(variable_index);
      beat.literal_polarity = polarity;
      beat.literal_used     = used;
      put_beat(beat);
   endtask

   task automatic send_check(input logic [15:0] values);
      cbfc_pkg::req_type beat;
      beat = noisy_beat(cbfc_pkg::KIND_CHECK);
      beat.assignment = values;
      put_beat(beat);
   endtask

   task automatic send_solve(input logic [15:0] values, input logic [15:0] fixed);
      cbfc_pkg::req_type beat;
      beat = noisy_beat(cbfc_pkg::KIND_SOLVE);
      beat.assignment = values;
      beat.fixed_mask = fixed;
      put_beat(beat);
   endtask

   // csr writes only once every answer is back, so the block is idle
   task automatic set_config(input int clauses_data, input int vars_data);
      req_valid <= 1'b0;
      while (formula_sb.awaited_answers.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= cbfc_pkg::REG_CLAUSES_IN_USE;
      csr_write_data   <= 7'(clauses_data);
      @(posedge clock);
      formula_sb.write_register(cbfc_pkg::REG_CLAUSES_IN_USE, 7'(clauses_data));
      csr_index      <= cbfc_pkg::REG_VARS_IN_USE;
      csr_write_data <= 7'(vars_data);
      @(posedge clock);
      formula_sb.write_register(cbfc_pkg::REG_VARS_IN_USE, 7'(vars_data));
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int          pick;
      int          free_count;
      int          lit_var;
      int          live_vars;
      int          clauses_data;
      int          vars_data;
      logic [15:0] free_bits;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset csrs: no clauses in use, all 16 variables, so every assignment holds
      send_check(16'hFFFF);
      // all 16 variables free: count reaches 65536, nothing frozen
      send_solve(16'h0000, 16'h0000);
      put_beat(noisy_beat(cbfc_pkg::KIND_NONE));

      // small known formula in rows 0..3
      send_literal(0, 0, 0, 1'b1, 1'b1);    // x0 | ~x1 | x2
      send_literal(0, 1, 1, 1'b0, 1'b1);
      send_literal(0, 2, 2, 1'b1, 1'b1);
      send_literal(1, 0, 0, 1'b0, 1'b1);    // ~x0 | x1
      send_literal(1, 1, 1, 1'b1, 1'b1);
      send_literal(1, 2, 15, 1'b1, 1'b0);
      send_literal(2, 0, 3, 1'b1, 1'b1);    // x3 | x12, x12 lies beyond the live variables
      send_literal(2, 1, 12, 1'b1, 1'b1);
      send_literal(2, 2, 15, 1'b0, 1'b0);
      send_literal(3, 0, 0, 1'b1, 1'b0);    // empty clause
      send_literal(3, 1, 7, 1'b1, 1'b0);
      send_literal(3, 2, 15, 1'b1, 1'b0);
      // slot past the row width must leave row 1 alone
      send_literal(1, 3, 0, 1'b1, 1'b1);

      // fill the rows after the known formula so no row in use is read before written
      for (int r = KNOWN_ROWS; r < FILLED_ROWS; r++)
         for (int s = 0; s < ROW_SLOTS; s++)
            send_literal(r, s, $urandom_range(15), $urandom_range(1), $urandom_range(9) != 0);

      // empty clause in use: nothing satisfies, all live variables reported frozen at 0
      set_config(4, 4);
      send_solve(16'h0000, 16'h0000);
      send_check(16'hFFFF);

      set_config(3, 4);
      send_solve(16'h0000, 16'h0000);
      send_check(16'h0009);
      send_check(16'hFFF7);
      // x3 fixed low, x12 bit ignored: the third clause cannot hold
      send_solve(16'h1000, 16'h1008);
      // everything fixed: a single assignment is tried
      send_solve(16'h0008, 16'hFFFF);

      // zero variables: only the empty assignment
      set_config(3, 0);
      send_check(16'hFFFF);
      send_solve(16'hFFFF, 16'h0000);

      // both csrs above their maximum saturate, all register bits set; the empty clause
      // in row 3 ends every assignment before any unfilled row is reached
      set_config(127, 31);
      send_solve($urandom, 16'hFFFC);
      send_check(16'h0000);
      send_check(16'hFFFF);

      // random phases, each under its own csr setting; the last one runs without idling
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(5))
            0:       clauses_data = 0;
            1:       clauses_data = FILLED_ROWS;
            default: clauses_data = $urandom_range(FILLED_ROWS - 1, 1);
         endcase
         case ($urandom_range(5))
            0:       vars_data = 0;
            1:       vars_data = 16;
            2:       vars_data = $urandom_range(31, 17);
            3:       vars_data = 1;
            default: vars_data = $urandom_range(15, 2);
         endcase
         live_vars = (vars_data > 16) ? 16 : vars_data;
         // upper write data bits are outside the 5-bit register
         set_config(clauses_data, vars_data | ($urandom_range(3) << 5));

         if (phase == RANDOM_PHASES - 1)
            idle_percent <= 0;
         else
            case ($urandom_range(2))
               0:       idle_percent <= 0;
               1:       idle_percent <= 10;
               default: idle_percent <= 35;
            endcase
         if (phase == 0)
            long_hold_request <= 1'b1;

         repeat (ITEMS_PER_PHASE) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
               // literals mostly on live variables so the formula stays meaningful
               lit_var = (live_vars > 0 && $urandom_range(3) != 0) ?
                         $urandom_range(live_vars - 1) : $urandom_range(15);
               send_literal($urandom_range(FILLED_ROWS - 1),
                            ($urandom_range(9) == 0) ? 3 : $urandom_range(2),
                            lit_var, $urandom_range(1), $urandom_range(7) != 0);
            end else if (pick < 55) begin
               send_check($urandom);
            end else if (pick < 95) begin
               // few free variables keep the walk short, now and then a wide one
               free_count = ($urandom_range(9) == 0) ? $urandom_range(10, 7) : $urandom_range(6);
               free_bits  = '0;
               while ($countones(free_bits) < free_count)
                  free_bits[$urandom_range(15)] = 1'b1;
               send_solve($urandom, ~free_bits);
            end else begin
               put_beat(noisy_beat(cbfc_pkg::KIND_NONE));
            end
         end
      end

      req_valid <= 1'b0;
      while (formula_sb.awaited_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (formula_sb.mismatches == 0 && formula_sb.awaited_answers.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
